// ----- hw/rtl/chse_pkg.sv -----
package chse_pkg;

  // Default sizing of the record store and of the key.
  localparam int unsigned CAPACITY_DEF      = 4096;
  localparam int unsigned MAX_KEY_BYTES_DEF = 8;

  // The bucket is the low two key bytes, so the head table is fixed.
  localparam int unsigned HEAD_AW    = 16;
  localparam int unsigned HEAD_COUNT = 1 << HEAD_AW;

  // Field widths of the interface.
  localparam int unsigned KEY_W = 64;
  localparam int unsigned CFG_W = 4;

  // Register reset value and the clamp floor of the key width.
  localparam logic [CFG_W-1:0] KEY_BYTES_RESET = 4'd8;
  localparam logic [CFG_W-1:0] KEY_BYTES_MIN   = 4'd3;

  // Operation codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // Input item.
  typedef struct packed {
    logic             operation;
    logic [KEY_W-1:0] key;
  } chse_in_t;

  // Result item.
  typedef struct packed {
    logic found;
    logic added;
    logic full_res;
  } chse_out_t;

  // Control sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HEAD,
    ST_WALK,
    ST_APPEND,
    ST_LINK,
    ST_RESULT
  } chse_state_e;

endpackage

// ----- hw/rtl/chained_hash_set_engine_unit.sv -----
// Hash set of pre-hashed keys with separate chaining. Each input transfer
// inserts a key or queries it, and each one produces exactly one result
// transfer (found, added, full_res). The bucket is the low 16 key bits, which
// index a 65536-entry head table; records live in a key memory and a link
// memory of CAPACITY entries, taken in allocation order and appended to the
// tail of their chain. After reset the head table is cleared by a pass over
// all 65536 entries, one entry per cycle, during which input is stalled;
// key_bytes writes are taken at any time. An item then goes through a head
// lookup, a walk along its chain and a result state; an insert that adds a
// record also passes an append state and, when the chain is not empty, a
// link state. The walk rate is one record per cycle, set by the single
// registered read port of the record memories. The next item is
// accepted while a result still waits on a stalled output.
module chained_hash_set_engine_unit #(
  parameter int unsigned CAPACITY      = chse_pkg::CAPACITY_DEF,
  parameter int unsigned MAX_KEY_BYTES = chse_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [chse_pkg::CFG_W-1:0]     cfg_wdata_i,
  // Input channel.
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  chse_pkg::chse_in_t             in_data_i,
  // Output channel.
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output chse_pkg::chse_out_t            out_data_o
);

  import chse_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned PW = $clog2(CAPACITY + 1);
  localparam int unsigned KW = 8 * MAX_KEY_BYTES;

  // Control state.
  chse_state_e         state_q, state_d;
  logic [HEAD_AW-1:0]  clr_addr_q, clr_addr_d;
  logic [PW-1:0]       count_q, count_d;
  logic [CFG_W-1:0]    key_bytes_q;
  logic                out_valid_q, out_valid_d;

  // Item payload.
  logic                op_q, op_d;
  logic [KW-1:0]       key_q, key_d;
  logic [PW-1:0]       cur_q, cur_d;
  logic [PW-1:0]       tail_q, tail_d;
  chse_out_t           res_q, res_d;
  chse_out_t           out_data_q, out_data_d;

  // Memory ports.
  logic                head_we;
  logic [HEAD_AW-1:0]  head_waddr;
  logic [PW-1:0]       head_wdata;
  logic [PW-1:0]       head_rdata;
  logic                key_we;
  logic                link_we;
  logic [AW-1:0]       link_waddr;
  logic [PW-1:0]       link_wdata;
  logic [AW-1:0]       rec_raddr;
  logic [KW-1:0]       key_rdata;
  logic [PW-1:0]       link_rdata;

  logic [CFG_W-1:0]    kb_eff;
  logic [KW-1:0]       key_mask;
  logic [PW-1:0]       new_ptr;
  logic [PW-1:0]       head_idx;
  logic [PW-1:0]       link_idx;
  logic [PW-1:0]       tail_idx;
  logic                store_full;
  logic                walk_miss;

  // Effective key width, clamped to the supported range.
  always_comb begin
    if (key_bytes_q < KEY_BYTES_MIN) begin
      kb_eff = KEY_BYTES_MIN;
    end else if (key_bytes_q > CFG_W'(MAX_KEY_BYTES)) begin
      kb_eff = CFG_W'(MAX_KEY_BYTES);
    end else begin
      kb_eff = key_bytes_q;
    end
  end

  // Byte mask of the key bytes that are stored and compared.
  always_comb begin
    for (int i = 0; i < int'(MAX_KEY_BYTES); i++) begin
      key_mask[8*i +: 8] = (CFG_W'(i) < kb_eff) ? 8'hff : 8'h00;
    end
  end

  // Pointers hold a record number plus one; these give memory indexes.
  assign new_ptr    = count_q + PW'(1);
  assign head_idx   = head_rdata - PW'(1);
  assign link_idx   = link_rdata - PW'(1);
  assign tail_idx   = tail_q - PW'(1);
  assign store_full = (count_q >= PW'(CAPACITY));

  // Head table, cleared by the sequencer after reset.
  chse_ram #(
    .WIDTH (PW),
    .DEPTH (HEAD_COUNT)
  ) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .raddr_i (in_data_i.key[HEAD_AW-1:0]),
    .rdata_o (head_rdata)
  );

  // Stored keys, masked when written.
  chse_ram #(
    .WIDTH (KW),
    .DEPTH (CAPACITY)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (key_q),
    .raddr_i (rec_raddr),
    .rdata_o (key_rdata)
  );

  // Chain links of the records.
  chse_ram #(
    .WIDTH (PW),
    .DEPTH (CAPACITY)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (rec_raddr),
    .rdata_o (link_rdata)
  );

  // Sequencer: clear pass, head lookup, chain walk, append and result.
  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    count_d     = count_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_data_d  = out_data_q;
    op_d        = op_q;
    key_d       = key_q;
    cur_d       = cur_q;
    tail_d      = tail_q;
    res_d       = res_q;
    in_stall_o  = 1'b1;
    head_we     = 1'b0;
    head_waddr  = key_q[HEAD_AW-1:0];
    head_wdata  = new_ptr;
    key_we      = 1'b0;
    link_we     = 1'b0;
    link_waddr  = count_q[AW-1:0];
    link_wdata  = '0;
    rec_raddr   = head_idx[AW-1:0];
    walk_miss   = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_addr_q;
        head_wdata = '0;
        clr_addr_d = clr_addr_q + HEAD_AW'(1);
        if (&clr_addr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          op_d    = in_data_i.operation;
          key_d   = in_data_i.key[KW-1:0] & key_mask;
          tail_d  = '0;
          res_d   = '0;
          state_d = ST_HEAD;
        end
      end
      ST_HEAD: begin
        // Head pointer is back; an empty bucket ends the search at once.
        if (head_rdata == '0) begin
          walk_miss = 1'b1;
        end else begin
          rec_raddr = head_idx[AW-1:0];
          cur_d     = head_rdata;
          state_d   = ST_WALK;
        end
      end
      ST_WALK: begin
        // Compare the record just read, then follow its link.
        rec_raddr = link_idx[AW-1:0];
        if ((key_rdata & key_mask) == key_q) begin
          res_d.found = 1'b1;
          state_d     = ST_RESULT;
        end else begin
          tail_d = cur_q;
          if (link_rdata == '0) begin
            walk_miss = 1'b1;
          end else begin
            cur_d = link_rdata;
          end
        end
      end
      ST_APPEND: begin
        // Write the new record and hook it to an empty bucket directly.
        key_we      = 1'b1;
        link_we     = 1'b1;
        count_d     = new_ptr;
        res_d.added = 1'b1;
        if (tail_q == '0) begin
          head_we = 1'b1;
          state_d = ST_RESULT;
        end else begin
          state_d = ST_LINK;
        end
      end
      ST_LINK: begin
        // The count already holds the new record's pointer.
        link_we    = 1'b1;
        link_waddr = tail_idx[AW-1:0];
        link_wdata = count_q;
        state_d    = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // End of an unsuccessful search: an insert appends unless the store is full.
    if (walk_miss) begin
      if (op_q == OP_INSERT) begin
        if (store_full) begin
          res_d.full_res = 1'b1;
          state_d        = ST_RESULT;
        end else begin
          state_d = ST_APPEND;
        end
      end else begin
        state_d = ST_RESULT;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      key_bytes_q <= KEY_BYTES_RESET;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        key_bytes_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    cur_q      <= cur_d;
    tail_q     <= tail_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTH
  // A finished result waits while the previous one is still stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESULT) && out_valid_q && out_stall_i |=> (state_q == ST_RESULT))
    else $error("result overwrote a stalled output");

  // Every append allocates exactly one record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_APPEND) |=> (count_q == $past(count_q) + PW'(1)))
    else $error("record count did not advance on append");

  // At most one outcome flag is set in a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($countones({out_data_q.found, out_data_q.added,
                                 out_data_q.full_res}) <= 1))
    else $error("conflicting result flags");

  // Linking a tail only happens for a non-empty chain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LINK) |-> (tail_q != '0) && ($past(state_q) == ST_APPEND))
    else $error("tail link written without a tail record");
`endif

endmodule

// ----- hw/rtl/chse_ram.sv -----
module chse_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
